// ===== hdl/status_led_pattern_sequencer_top_macros.svh =====
// Assertion macros for the status LED sequencer checker.
// Included by the checker file; needs i_clk and i_rst_n in scope.
`ifndef STATUS_LED_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define STATUS_LED_PATTERN_SEQUENCER_TOP_MACROS_SVH

// Clocked property, switched off while reset is held.
`define SLPS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define SLPS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/slps_pkg.sv =====
// Shared types and constants of the status LED pattern sequencer.
// No dependencies; imported by the top level.
package slps_pkg;

    // Configuration register, index, default timer and stream data widths
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int TIMER_W_DEF   = 16;
    localparam int TDATA_W       = 8;

    // Register reset values, in ticks
    localparam logic [CFG_W-1:0] ALT_PERIOD_RST   = 16'd300;
    localparam logic [CFG_W-1:0] SLOW_PERIOD_RST  = 16'd800;
    localparam logic [CFG_W-1:0] BEACON_PERIOD_RST = 16'd5000;
    localparam logic [CFG_W-1:0] FLASH_ON_RST     = 16'd150;
    localparam logic [CFG_W-1:0] QUICK_PERIOD_RST = 16'd150;
    localparam logic [CFG_W-1:0] SEND_PULSE_RST   = 16'd80;

    // Step counts of the reset blink sequences
    localparam int QUICK_SHORT_STEPS = 4;
    localparam int QUICK_LONG_STEPS  = 6;

    // LED bit positions and masks
    localparam int LED_R = 0;
    localparam int LED_Y = 1;
    localparam int LED_G = 2;
    localparam logic [2:0] LED_MASK_R   = 3'b001;
    localparam logic [2:0] LED_MASK_Y   = 3'b010;
    localparam logic [2:0] LED_MASK_ALL = 3'b111;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MODE = 2'd1,
        OP_SEND = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        MODE_BOOT        = 3'd0,
        MODE_CONNECTING  = 3'd1,
        MODE_NORMAL      = 3'd2,
        MODE_PORTAL      = 3'd3,
        MODE_OFFLINE     = 3'd4,
        MODE_SENSOR_FAIL = 3'd5,
        MODE_RESET_SHORT = 3'd6,
        MODE_RESET_LONG  = 3'd7
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALT_PERIOD    = 3'd0,
        CFG_SLOW_PERIOD   = 3'd1,
        CFG_BEACON_PERIOD = 3'd2,
        CFG_FLASH_ON      = 3'd3,
        CFG_QUICK_PERIOD  = 3'd4,
        CFG_SEND_PULSE    = 3'd5
    } t_cfg_idx;

endpackage

// ===== hdl/status_led_pattern_sequencer_top.sv =====
// Status LED pattern sequencer: mode, timers and LED levels in one pass.
// Depends on slps_pkg.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   op, mode
//  m_axis    out  m_axis_tvalid/m_axis_tready   red_on, yellow_on, green_on
//  cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
// One transfer in per cycle while the output is not stalled; its result passes
// the input register, then the state update and result register. The rate is
// one per cycle, set by the single state-update pass. Reset sets state, valid
// flags and configuration but not the data registers. A stalled output holds
// the pipe; the input keeps taking transfers while its register drains.
module status_led_pattern_sequencer_top
    import slps_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // [1:0] op, [4:2] mode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // [0] red_on, [1] yellow_on, [2] green_on
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int TW    = TIMER_WIDTH;
    localparam int CMP_W = (TW > CFG_W) ? TW : CFG_W;

    // Configuration registers
    logic [CFG_W-1:0] r_alt_period, r_slow_period, r_beacon_period;
    logic [CFG_W-1:0] r_flash_on, r_quick_period, r_send_pulse;

    // Pipeline registers
    logic        r_in_valid;
    t_op         r_in_op;
    t_mode       r_in_mode;
    logic        r_out_valid;
    logic [2:0]  r_out_led;

    // Sequencer state
    t_mode       r_mode, n_mode;
    logic [TW-1:0] r_elapsed, n_elapsed;
    logic [2:0]  r_phase, n_phase;
    logic [2:0]  r_led, n_led;
    logic [TW-1:0] r_flash, n_flash;
    logic [TW-1:0] r_send, n_send;

    logic          w_step;
    logic [TW-1:0] w_elapsed_inc;
    logic [CMP_W-1:0] w_elapsed_cmp, w_tmax_cmp;
    logic          w_due_alt, w_due_slow, w_due_beacon, w_due_quick;
    logic [TW-1:0] w_flash_ld, w_send_ld;

    // Handshake: the state pass fires when the result register is free
    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_W-3){1'b0}}, r_out_led};

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_period    <= ALT_PERIOD_RST;
            r_slow_period   <= SLOW_PERIOD_RST;
            r_beacon_period <= BEACON_PERIOD_RST;
            r_flash_on      <= FLASH_ON_RST;
            r_quick_period  <= QUICK_PERIOD_RST;
            r_send_pulse    <= SEND_PULSE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ALT_PERIOD:    r_alt_period    <= i_cfg_data;
                CFG_SLOW_PERIOD:   r_slow_period   <= i_cfg_data;
                CFG_BEACON_PERIOD: r_beacon_period <= i_cfg_data;
                CFG_FLASH_ON:      r_flash_on      <= i_cfg_data;
                CFG_QUICK_PERIOD:  r_quick_period  <= i_cfg_data;
                CFG_SEND_PULSE:    r_send_pulse    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= t_op'(s_axis_tdata[1:0]);
            r_in_mode <= t_mode'(s_axis_tdata[4:2]);
        end
    end

    // Elapsed time, saturating, and period compares
    assign w_elapsed_inc = (r_elapsed != {TW{1'b1}}) ? (r_elapsed + TW'(1)) : r_elapsed;
    assign w_elapsed_cmp = CMP_W'(w_elapsed_inc);
    assign w_tmax_cmp    = CMP_W'({TW{1'b1}});
    assign w_due_alt     = w_elapsed_cmp >= CMP_W'(r_alt_period);
    assign w_due_slow    = w_elapsed_cmp >= CMP_W'(r_slow_period);
    assign w_due_beacon  = w_elapsed_cmp >= CMP_W'(r_beacon_period);
    assign w_due_quick   = w_elapsed_cmp >= CMP_W'(r_quick_period);

    // On-times saturated to the timer range
    assign w_flash_ld = (CMP_W'(r_flash_on) > w_tmax_cmp) ? {TW{1'b1}}
                                                          : TW'(r_flash_on);
    assign w_send_ld  = (CMP_W'(r_send_pulse) > w_tmax_cmp) ? {TW{1'b1}}
                                                            : TW'(r_send_pulse);

    // Next state for one transfer
    always_comb begin
        n_mode    = r_mode;
        n_elapsed = r_elapsed;
        n_phase   = r_phase;
        n_led     = r_led;
        n_flash   = r_flash;
        n_send    = r_send;
        if (w_step) begin
            case (r_in_op)
                OP_TICK: begin
                    // countdowns first
                    if (r_flash != '0) begin
                        n_flash = r_flash - TW'(1);
                        if (n_flash == '0) begin
                            n_led[LED_R] = 1'b0;
                            n_led[LED_Y] = 1'b0;
                        end
                    end
                    if (r_send != '0) begin
                        n_send = r_send - TW'(1);
                        if (n_send == '0) begin
                            n_led[LED_G] = 1'b0;
                        end
                    end
                    n_elapsed = w_elapsed_inc;
                    // mode action
                    case (r_mode)
                        MODE_PORTAL: begin
                            if (w_due_alt) begin
                                n_elapsed = '0;
                                n_phase   = (r_phase == 3'd0) ? 3'd1 : 3'd0;
                                n_led     = (r_phase == 3'd0) ? LED_MASK_R : LED_MASK_Y;
                            end
                        end
                        MODE_CONNECTING: begin
                            if (w_due_slow) begin
                                n_elapsed = '0;
                                n_phase   = (r_phase == 3'd0) ? 3'd1 : 3'd0;
                                n_led     = (r_phase == 3'd0) ? LED_MASK_Y : 3'b000;
                            end
                        end
                        MODE_OFFLINE, MODE_SENSOR_FAIL: begin
                            if (w_due_beacon) begin
                                n_elapsed    = '0;
                                n_flash      = w_flash_ld;
                                n_led[LED_R] = 1'b0;
                                n_led[LED_Y] = 1'b0;
                                if (w_flash_ld != '0) begin
                                    if (r_mode == MODE_OFFLINE) begin
                                        n_led[LED_Y] = 1'b1;
                                    end else begin
                                        n_led[LED_R] = 1'b1;
                                    end
                                end
                            end
                        end
                        MODE_RESET_SHORT: begin
                            if (r_phase < 3'(QUICK_SHORT_STEPS) && w_due_quick) begin
                                n_elapsed = '0;
                                n_led     = r_phase[0] ? 3'b000 : LED_MASK_Y;
                                n_phase   = r_phase + 3'd1;
                            end
                        end
                        MODE_RESET_LONG: begin
                            if (r_phase < 3'(QUICK_LONG_STEPS) && w_due_quick) begin
                                n_elapsed = '0;
                                n_led     = r_phase[0] ? 3'b000 : LED_MASK_ALL;
                                n_phase   = r_phase + 3'd1;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_MODE: begin
                    if (r_in_mode != r_mode) begin
                        n_mode    = r_in_mode;
                        n_phase   = 3'd0;
                        n_elapsed = '0;
                        // a running flash is cancelled
                        if (r_flash != '0) begin
                            n_flash      = '0;
                            n_led[LED_R] = 1'b0;
                            n_led[LED_Y] = 1'b0;
                        end
                        if (r_in_mode == MODE_BOOT) begin
                            n_led = LED_MASK_Y;
                        end else if (r_in_mode == MODE_CONNECTING ||
                                     r_in_mode == MODE_NORMAL) begin
                            n_led = 3'b000;
                        end
                    end
                end
                OP_SEND: begin
                    n_send       = w_send_ld;
                    n_led[LED_G] = (w_send_ld != '0);
                end
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_BOOT;
            r_elapsed <= '0;
            r_phase   <= 3'd0;
            r_led     <= 3'b000;
            r_flash   <= '0;
            r_send    <= '0;
        end else begin
            r_mode    <= n_mode;
            r_elapsed <= n_elapsed;
            r_phase   <= n_phase;
            r_led     <= n_led;
            r_flash   <= n_flash;
            r_send    <= n_send;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_led <= n_led;
        end
    end

endmodule

// ===== hdl/slps_checker.sv =====
// Port-level checks for the status LED sequencer, bound to the top level.
// Depends on status_led_pattern_sequencer_top_macros.svh.
`include "status_led_pattern_sequencer_top_macros.svh"

module slps_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    logic w_in_xfer;
    logic w_out_stall;

    assign w_in_xfer   = i_rst_n && s_axis_tvalid && s_axis_tready;
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;

    // A stalled result stays offered
    `SLPS_ASSERT(a_out_hold, w_out_stall |=> m_axis_tvalid, "result dropped while stalled")

    // A stalled result keeps its levels
    `SLPS_ASSERT(a_out_stable, w_out_stall |=> $stable(m_axis_tdata), "result changed in stall")

    // An input transfer, with reset released after it, leads to an offered result once it has passed both registers
    `SLPS_ASSERT_ALWAYS(a_in_to_out, (w_in_xfer ##1 i_rst_n) |=> m_axis_tvalid, "input lost")

    // Padding bits of the result stay zero
    `SLPS_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[7:3] == 5'b00000, "padding not zero")

endmodule

bind status_led_pattern_sequencer_top slps_checker u_slps_checker (.*);
